>>> design/clt_pkg.sv
// Shared constants and lookup functions for the circuit language tokenizer.
package clt_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int NUM_KW = 7;

    localparam logic [5:0] KIND_EOF     = 6'd0;
    localparam logic [5:0] KIND_NUMBER  = 6'd1;
    localparam logic [5:0] KIND_IDENT   = 6'd2;
    localparam logic [5:0] KIND_KW0     = 6'd3;
    localparam logic [5:0] KIND_SYM0    = 6'd10;
    localparam logic [5:0] KIND_OP0     = 6'd36;
    localparam logic [5:0] KIND_DIV     = 6'd44;
    localparam logic [5:0] KIND_UNKNOWN = 6'd45;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return (l >= 8'h61) && (l <= 8'h7A);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
    endfunction

    // keyword lengths: Pi Circuit Channel If All Measure Repeat
    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] r;
        unique case (k)
            3'd0: r = 3'd2;
            3'd1: r = 3'd7;
            3'd2: r = 3'd7;
            3'd3: r = 3'd2;
            3'd4: r = 3'd3;
            3'd5: r = 3'd7;
            3'd6: r = 3'd6;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
        logic [63:0] w;
        logic [2:0]  pos;
        unique case (k)
            3'd0: w = 64'("Pi");
            3'd1: w = 64'("Circuit");
            3'd2: w = 64'("Channel");
            3'd3: w = 64'("If");
            3'd4: w = 64'("All");
            3'd5: w = 64'("Measure");
            3'd6: w = 64'("Repeat");
            default: w = '0;
        endcase
        pos = kw_len(k) - 3'd1 - i;
        return w[8*pos +: 8];
    endfunction

    // first character of the pending operators < > = *
    function automatic logic [2:0] op_first(input logic [7:0] c);
        logic [2:0] r;
        unique case (c)
            8'h3C:   r = 3'b100;
            8'h3E:   r = 3'b101;
            CH_EQ:   r = 3'b110;
            CH_STAR: r = 3'b111;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] op_second(input logic [1:0] op);
        return (op == 2'd3) ? CH_STAR : CH_EQ;
    endfunction

    // single symbols; unknown bytes map to KIND_UNKNOWN
    function automatic logic [5:0] sym_kind(input logic [7:0] c);
        logic [5:0] r;
        unique case (c)
            8'h28: r = KIND_SYM0 + 6'd0;
            8'h29: r = KIND_SYM0 + 6'd1;
            8'h5B: r = KIND_SYM0 + 6'd2;
            8'h5D: r = KIND_SYM0 + 6'd3;
            8'h7B: r = KIND_SYM0 + 6'd4;
            8'h7D: r = KIND_SYM0 + 6'd5;
            8'h2C: r = KIND_SYM0 + 6'd6;
            8'h3B: r = KIND_SYM0 + 6'd7;
            8'h25: r = KIND_SYM0 + 6'd8;
            8'h23: r = KIND_SYM0 + 6'd9;
            8'h24: r = KIND_SYM0 + 6'd10;
            8'h26: r = KIND_SYM0 + 6'd11;
            8'h7C: r = KIND_SYM0 + 6'd12;
            8'h5E: r = KIND_SYM0 + 6'd13;
            8'h27: r = KIND_SYM0 + 6'd14;
            8'h22: r = KIND_SYM0 + 6'd15;
            8'h5C: r = KIND_SYM0 + 6'd16;
            8'h60: r = KIND_SYM0 + 6'd17;
            8'h21: r = KIND_SYM0 + 6'd18;
            8'h7E: r = KIND_SYM0 + 6'd19;
            8'h3A: r = KIND_SYM0 + 6'd20;
            8'h3F: r = KIND_SYM0 + 6'd21;
            8'h2E: r = KIND_SYM0 + 6'd22;
            8'h40: r = KIND_SYM0 + 6'd23;
            8'h2B: r = KIND_SYM0 + 6'd24;
            8'h2D: r = KIND_SYM0 + 6'd25;
            default: r = KIND_UNKNOWN;
        endcase
        return r;
    endfunction

endpackage

>>> design/circuit_language_tokenizer_top.sv
// Streaming tokenizer for a circuit description language, one source byte per transfer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------------
//  in      | into      | in_valid/in_stall  | char_in, end_of_input
//  out     | out of    | out_valid/out_stall| token_kind, token_start, token_length, last_of_item
//
// One byte is taken per cycle while in_stall is low; the lexer state updates in the cycle of the transfer.
// A byte gives zero, one or two tokens, held in a two-entry result buffer.
// A byte that yields two tokens holds off input while the buffer drains.
// in_stall is high while the buffer cannot take a full byte's results.
// Reset clears lexer state and empties the buffer; no clearing pass.
module circuit_language_tokenizer_top
    import clt_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              char_in,
    input  logic                    end_of_input,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [5:0]              token_kind,
    output logic [OFFSET_WIDTH-1:0] token_start,
    output logic [LENGTH_WIDTH-1:0] token_length,
    output logic                    last_of_item
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_COMMENT,
        MODE_OP,
        MODE_SLASH
    } mode_t;

    typedef struct packed {
        logic [5:0]              kind;
        logic [OFFSET_WIDTH-1:0] start;
        logic [LENGTH_WIDTH-1:0] length;
        logic                    last;
    } token_t;

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;
    localparam logic [LENGTH_WIDTH-1:0] LEN_ONE = LENGTH_WIDTH'(1);
    localparam logic [LENGTH_WIDTH-1:0] LEN_TWO = LENGTH_WIDTH'(2);

    mode_t                   mode_reg, mode_next;
    logic [1:0]              op_reg, op_next;
    logic [OFFSET_WIDTH-1:0] start_reg, start_next;
    logic [LENGTH_WIDTH-1:0] len_reg, len_next;
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    logic [NUM_KW-1:0]       kw_reg, kw_next;
    logic                    finished_reg, finished_next;

    token_t                  slot0_reg, slot0_next;
    token_t                  slot1_reg, slot1_next;
    logic [1:0]              cnt_reg, cnt_next;

    logic                    accept;
    logic                    pop;
    logic                    valid_a, valid_b;
    token_t                  tok_a, tok_b;
    logic [1:0]              n_new;

    assign pop       = out_valid && !out_stall;
    assign in_stall  = !((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop));
    assign accept    = in_valid && !in_stall;
    assign out_valid = (cnt_reg != 2'd0);

    assign token_kind   = slot0_reg.kind;
    assign token_start  = slot0_reg.start;
    assign token_length = slot0_reg.length;
    assign last_of_item = slot0_reg.last;

    function automatic logic [NUM_KW-1:0] kw_update(input logic [NUM_KW-1:0] flags,
                                                   input logic [LENGTH_WIDTH-1:0] idx,
                                                   input logic [7:0] c);
        logic [NUM_KW-1:0] r;
        r = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (flags[k] && (idx < LENGTH_WIDTH'(kw_len(3'(k))))
                && (kw_char(3'(k), idx[2:0]) == c))
            begin
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

    // lexer step
    always_comb
    begin
        logic       consumed;
        logic       advance;
        logic [2:0] opf;
        logic [5:0] id_kind;

        mode_next     = mode_reg;
        op_next       = op_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        kw_next       = kw_reg;
        finished_next = finished_reg;
        valid_a       = 1'b0;
        valid_b       = 1'b0;
        tok_a         = '0;
        tok_b         = '0;
        consumed      = 1'b0;
        advance       = 1'b1;
        opf           = op_first(char_in);

        id_kind = KIND_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (kw_reg[k] && (len_reg == LENGTH_WIDTH'(kw_len(3'(k)))))
            begin
                id_kind = KIND_KW0 + 6'(k);
            end
        end

        // flush of the pending token into slot A
        tok_a.start = start_reg;
        unique case (mode_reg)
            MODE_NUM:
            begin
                tok_a.kind   = KIND_NUMBER;
                tok_a.length = len_reg;
            end
            MODE_IDENT:
            begin
                tok_a.kind   = id_kind;
                tok_a.length = len_reg;
            end
            MODE_OP:
            begin
                tok_a.kind   = KIND_OP0 + {3'b000, op_reg, 1'b0};
                tok_a.length = LEN_ONE;
            end
            MODE_SLASH:
            begin
                tok_a.kind   = KIND_DIV;
                tok_a.length = LEN_ONE;
            end
            default:
            begin
                tok_a.kind   = KIND_EOF;
                tok_a.length = '0;
            end
        endcase

        tok_b.kind   = KIND_EOF;
        tok_b.start  = pos_reg;
        tok_b.length = '0;

        if (finished_reg)
        begin
            valid_b = 1'b1;
        end
        else if (end_of_input)
        begin
            valid_a       = (mode_reg == MODE_NUM) || (mode_reg == MODE_IDENT)
                         || (mode_reg == MODE_OP) || (mode_reg == MODE_SLASH);
            valid_b       = 1'b1;
            mode_next     = MODE_IDLE;
            finished_next = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_NUM:
                begin
                    if (is_digit(char_in) || (char_in == 8'h65) || (char_in == 8'h2B)
                        || (char_in == 8'h2D) || (char_in == 8'h2E))
                    begin
                        len_next = (len_reg == LEN_MAX) ? LEN_MAX : len_reg + LEN_ONE;
                        consumed = 1'b1;
                    end
                    else
                    begin
                        valid_a   = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_alpha(char_in) || is_digit(char_in) || (char_in == 8'h5F))
                    begin
                        kw_next  = kw_update(kw_reg, len_reg, char_in);
                        len_next = (len_reg == LEN_MAX) ? LEN_MAX : len_reg + LEN_ONE;
                        consumed = 1'b1;
                    end
                    else
                    begin
                        valid_a   = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_COMMENT:
                begin
                    if (char_in == CH_LF)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    consumed = 1'b1;
                end
                MODE_OP:
                begin
                    valid_a   = 1'b1;
                    mode_next = MODE_IDLE;
                    if (char_in == op_second(op_reg))
                    begin
                        tok_a.kind   = KIND_OP0 + {3'b000, op_reg, 1'b1};
                        tok_a.length = LEN_TWO;
                        consumed     = 1'b1;
                    end
                end
                MODE_SLASH:
                begin
                    if (char_in == CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                        consumed  = 1'b1;
                    end
                    else
                    begin
                        valid_a   = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase

            if (!consumed)
            begin
                tok_b.start  = pos_reg;
                tok_b.length = LEN_ONE;
                priority if (is_space(char_in))
                begin
                end
                else if (char_in == CH_NUL)
                begin
                    valid_b       = 1'b1;
                    tok_b.kind    = KIND_EOF;
                    tok_b.length  = '0;
                    finished_next = 1'b1;
                    advance       = 1'b0;
                end
                else if (char_in == CH_SLASH)
                begin
                    mode_next  = MODE_SLASH;
                    start_next = pos_reg;
                end
                else if (is_digit(char_in))
                begin
                    mode_next  = MODE_NUM;
                    start_next = pos_reg;
                    len_next   = LEN_ONE;
                end
                else if (is_alpha(char_in))
                begin
                    mode_next  = MODE_IDENT;
                    start_next = pos_reg;
                    len_next   = LEN_ONE;
                    kw_next    = kw_update('1, '0, char_in);
                end
                else if (opf[2])
                begin
                    mode_next  = MODE_OP;
                    op_next    = opf[1:0];
                    start_next = pos_reg;
                end
                else
                begin
                    valid_b    = 1'b1;
                    tok_b.kind = sym_kind(char_in);
                end
            end

            if (advance)
            begin
                pos_next = pos_reg + OFFSET_WIDTH'(1);
            end
        end

        tok_a.last = !valid_b;
        tok_b.last = 1'b1;
    end

    // result buffer
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        n_new      = {1'b0, valid_a} + {1'b0, valid_b};

        if (accept)
        begin
            slot0_next = valid_a ? tok_a : tok_b;
            slot1_next = tok_b;
            cnt_next   = n_new;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            op_reg       <= '0;
            start_reg    <= '0;
            len_reg      <= '0;
            pos_reg      <= '0;
            kw_reg       <= '1;
            finished_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg     <= mode_next;
                op_reg       <= op_next;
                start_reg    <= start_next;
                len_reg      <= len_next;
                pos_reg      <= pos_next;
                kw_reg       <= kw_next;
                finished_reg <= finished_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // assertions
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> (!slot0_reg.last && slot1_reg.last))
        else $error("two buffered tokens not ordered as first then last");

    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished flag cleared without reset");

    a_eof_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (token_kind == KIND_EOF)) |-> (token_length == '0))
        else $error("eof token with nonzero length");

    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (cnt_reg != 2'd0) || $past(!valid_a && !valid_b))
        else $error("accepted item's tokens lost");

endmodule
